@@ rtl/core/i2cm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_ACK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_PULSE = 2'd1,
        EV_STOP  = 2'd2
    } event_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = 4;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic [7:0] slave_data;
        logic       slave_ack;
    } in_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic       line_level;
        logic       master_released;
        logic [7:0] rx_byte;
        logic       ack_level;
        logic       last;
    } out_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctl_t;

    typedef struct packed {
        logic in_known;
        logic last_event;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/i2cm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output i2cm_pkg::ctl_t     ctl,
    input  wire i2cm_pkg::sts_t sts
);
    import i2cm_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (ctl.load && sts.in_known) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (ctl.step && sts.last_event) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        ctl.load = s_valid && s_ready;
        ctl.step = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
        if (ctl.step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        m_valid = m_valid_reg;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending beat dropped under stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.step && sts.last_event) |=> (state_reg == ST_IDLE))
        else $error("run did not end on last event");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.load && !sts.in_known) |=> (state_reg == ST_IDLE))
        else $error("unknown command started a run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.load && sts.in_known) |=> (state_reg == ST_RUN))
        else $error("known command did not start a run");

endmodule

`default_nettype wire

@@ rtl/core/i2cm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cm_datapath (
    input  wire logic           aclk,
    input  wire i2cm_pkg::in_t  s_data,
    output i2cm_pkg::out_t      m_data,
    input  wire i2cm_pkg::ctl_t ctl,
    output i2cm_pkg::sts_t      sts
);
    import i2cm_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(BYTE_BITS - 1);
    localparam logic [CNT_W-1:0] ACK_SLOT  = CNT_W'(BYTE_BITS);

    cmd_t           cmd_reg;
    logic [7:0]     tx_reg;
    logic [7:0]     sdat_reg;
    logic           nack_reg;
    logic           sack_reg;
    logic [7:0]     shift_reg;
    logic [CNT_W-1:0] bit_count_reg;
    out_t           out_reg;

    out_t           ev;
    logic [7:0]     shift_next;

    always_comb begin
        sts.in_known = (s_data.command inside {[CMD_START:CMD_ACK]});
        shift_next   = {shift_reg[6:0], sdat_reg[7]};
        ev           = '0;
        case (cmd_reg)
            CMD_START: begin
                ev.event_kind = EV_START;
                ev.last       = 1'b1;
            end
            CMD_STOP: begin
                ev.event_kind      = EV_STOP;
                ev.line_level      = 1'b1;
                ev.master_released = 1'b1;
                ev.last            = 1'b1;
            end
            CMD_WRITE: begin
                ev.event_kind = EV_PULSE;
                if (bit_count_reg == ACK_SLOT) begin
                    ev.line_level      = sack_reg;
                    ev.master_released = 1'b1;
                    ev.ack_level       = sack_reg;
                    ev.last            = 1'b1;
                end else begin
                    ev.line_level      = tx_reg[7];
                    ev.master_released = tx_reg[7];
                end
            end
            CMD_READ: begin
                ev.event_kind      = EV_PULSE;
                ev.line_level      = sdat_reg[7];
                ev.master_released = 1'b1;
                if (bit_count_reg == LAST_BIT) begin
                    ev.rx_byte = shift_next;
                    ev.last    = 1'b1;
                end
            end
            CMD_ACK: begin
                ev.event_kind      = EV_PULSE;
                ev.line_level      = nack_reg;
                ev.master_released = nack_reg;
                ev.last            = 1'b1;
            end
            default: begin
                ev.last = 1'b1;
            end
        endcase
        sts.last_event = ev.last;
        m_data         = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg       <= cmd_t'(s_data.command);
            tx_reg        <= s_data.tx_byte;
            sdat_reg      <= s_data.slave_data;
            nack_reg      <= s_data.send_nack;
            sack_reg      <= s_data.slave_ack;
            shift_reg     <= '0;
            bit_count_reg <= '0;
        end else if (ctl.step) begin
            tx_reg        <= {tx_reg[6:0], 1'b0};
            sdat_reg      <= {sdat_reg[6:0], 1'b0};
            bit_count_reg <= bit_count_reg + CNT_W'(1);
            if (cmd_reg == CMD_READ) begin
                shift_reg <= shift_next;
            end
        end
        if (ctl.step) begin
            out_reg <= ev;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/i2c_bit_level_master_core.sv @@
// Bit-level I2C master core.
// Input channel (s_valid/s_ready/s_data): one beat is one bus command:
// start, stop, write byte, read byte or send acknowledge bit.
// Result channel (m_valid/m_ready/m_data): one beat per bus event; the
// final beat of a command carries last, the received byte and the sampled
// acknowledge level.
// Start, stop and acknowledge give one event; a read byte gives eight and
// a write byte nine. Events leave one per cycle from the event sequencer
// while no stall on m_ready holds a pending beat; the command beat is first
// registered in the run state, and each event then in the output register.
// A new command is taken once the last event of the previous one sits in
// the output register, even while that beat still waits to be taken.
// Unknown command codes are taken and give no events.
// A stall on m_ready holds the output register and the sequencer.
// Reset (aresetn low, synchronous) drops any run in progress and any
// pending beat; the core then waits for a command.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bit_level_master_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire i2cm_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output i2cm_pkg::out_t       m_data
);
    import i2cm_pkg::*;

    ctl_t ctl;
    sts_t sts;

    i2cm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .sts     (sts)
    );

    i2cm_datapath u_datapath (
        .aclk   (aclk),
        .s_data (s_data),
        .m_data (m_data),
        .ctl    (ctl),
        .sts    (sts)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_i2c_bit_level_master_core.sv @@
`timescale 1ns / 1ps

module tb_i2c_bit_level_master_core;
    import i2cm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 250;
    localparam int CMD_CODE_MAX  = 7;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    in_t  cmd_queue[$];
    out_t events_due[$];

    logic [7:0] rx_shift  = 8'h00;
    logic [3:0] bits_moved = 4'd0;
    logic       sda_out   = 1'b1;
    logic       scl_out   = 1'b1;

    int errors      = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int send_run    = 0;
    int ready_gap   = 0;
    int recv_run    = 0;
    int hold_left   = 0;
    int events_taken = 0;
    bit hold_done   = 1'b0;

    i2c_bit_level_master_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int pick_gap(inout int run_left);
        int r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            run_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_t make_cmd(logic [2:0] code, logic [7:0] tx, logic nack,
                                     logic [7:0] sdat, logic sack);
        in_t c;
        c.command    = code;
        c.tx_byte    = tx;
        c.send_nack  = nack;
        c.slave_data = sdat;
        c.slave_ack  = sack;
        return c;
    endfunction

    function automatic in_t rand_cmd(logic [2:0] code);
        return make_cmd(code, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    function automatic out_t bus_event(event_t kind, logic level, logic released,
                                       logic [7:0] rx, logic ack, logic fin);
        out_t e;
        e.event_kind      = kind;
        e.line_level      = level;
        e.master_released = released;
        e.rx_byte         = rx;
        e.ack_level       = ack;
        e.last            = fin;
        return e;
    endfunction

    task automatic queue_bus_events(in_t c);
        logic b;
        case (c.command)
            CMD_START: begin
                sda_out    = 1'b0;
                scl_out    = 1'b0;
                bits_moved = 4'd0;
                events_due.push_back(bus_event(EV_START, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
            end
            CMD_STOP: begin
                sda_out    = 1'b1;
                scl_out    = 1'b1;
                bits_moved = 4'd0;
                events_due.push_back(bus_event(EV_STOP, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1));
            end
            CMD_WRITE: begin
                for (int i = 0; i < BYTE_BITS; i++) begin
                    b       = c.tx_byte[BYTE_BITS-1-i];
                    sda_out = b;
                    events_due.push_back(bus_event(EV_PULSE, b, b, 8'h00, 1'b0, 1'b0));
                end
                sda_out    = 1'b1;
                scl_out    = 1'b0;
                bits_moved = 4'(BYTE_BITS);
                events_due.push_back(bus_event(EV_PULSE, c.slave_ack, 1'b1, 8'h00,
                                               c.slave_ack, 1'b1));
            end
            CMD_READ: begin
                sda_out  = 1'b1;
                rx_shift = 8'h00;
                for (int i = 0; i < BYTE_BITS; i++) begin
                    b        = c.slave_data[BYTE_BITS-1-i];
                    rx_shift = {rx_shift[6:0], b};
                    events_due.push_back(bus_event(EV_PULSE, b, 1'b1,
                                                   (i == BYTE_BITS-1) ? rx_shift : 8'h00,
                                                   1'b0, i == BYTE_BITS-1));
                end
                scl_out    = 1'b0;
                bits_moved = 4'(BYTE_BITS);
            end
            CMD_ACK: begin
                sda_out    = c.send_nack;
                scl_out    = 1'b0;
                bits_moved = 4'd0;
                events_due.push_back(bus_event(EV_PULSE, c.send_nack, c.send_nack, 8'h00,
                                               1'b0, 1'b1));
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: advance to the next command once the current beat is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) queue_bus_events(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    s_data   <= cmd_queue.pop_front();
                    s_valid  <= 1'b1;
                    send_gap = pick_gap(send_run);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold to back up the core.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                events_taken++;
                ready_gap = pick_gap(recv_run);
            end
            if (!hold_done && events_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: compare each event beat with the oldest prediction.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (events_due.size() == 0) begin
                $display("%0t: unexpected event beat, expected none, actual %0h",
                         $time, m_data);
                errors++;
            end else begin
                want = events_due.pop_front();
                check_field("event_kind", want.event_kind, m_data.event_kind);
                check_field("line_level", want.line_level, m_data.line_level);
                check_field("master_released", want.master_released,
                            m_data.master_released);
                check_field("rx_byte", want.rx_byte, m_data.rx_byte);
                check_field("ack_level", want.ack_level, m_data.ack_level);
                check_field("last", want.last, m_data.last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int   counted;
        int   r;
        int   n;
        bit   timed_out;
        logic rd;
        in_t  c;

        cmd_queue.push_back(make_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 8'h00, 1'b1, 8'hFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_READ, 8'h00, 1'b0, 8'hFF, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_READ, 8'hFF, 1'b1, 8'h00, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_ACK, 8'h00, 1'b0, 8'h00, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_READ, 8'h3C, 1'b0, 8'h5A, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_ACK, 8'h00, 1'b1, 8'h00, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_ACK, 8'hFF, 1'b0, 8'hFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_READ, 8'hFF, 1'b1, 8'hFF, 1'b1));
        cmd_queue.push_back(rand_cmd(CMD_WRITE));
        for (int code = CMD_ACK + 1; code <= CMD_CODE_MAX; code++)
            cmd_queue.push_back(rand_cmd(3'(code)));
        cmd_queue.push_back(make_cmd(CMD_START, 8'hFF, 1'b1, 8'hFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_WRITE, 8'h01, 1'b1, 8'h80, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0));

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                cmd_queue.push_back(rand_cmd(CMD_START));
                c = rand_cmd(CMD_WRITE);
                rd = c.tx_byte[0];
                cmd_queue.push_back(c);
                n = $urandom_range(0, 4);
                for (int k = 0; k < n; k++) begin
                    if (rd) begin
                        cmd_queue.push_back(rand_cmd(CMD_READ));
                        c = rand_cmd(CMD_ACK);
                        c.send_nack = (k == n - 1);
                        cmd_queue.push_back(c);
                    end else begin
                        cmd_queue.push_back(rand_cmd(CMD_WRITE));
                    end
                end
                cmd_queue.push_back(rand_cmd(CMD_STOP));
                counted += 3 + (rd ? 2 * n : n);
            end else if (r < 93) begin
                cmd_queue.push_back(rand_cmd(3'($urandom_range(CMD_START, CMD_ACK))));
                counted++;
            end else begin
                cmd_queue.push_back(rand_cmd(3'($urandom_range(CMD_ACK + 1, CMD_CODE_MAX))));
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        timed_out = 1'b0;
        while (!timed_out && (cmd_queue.size() > 0 || s_valid || events_due.size() > 0)) begin
            @(negedge aclk);
            timed_out = (idle_cycles >= IDLE_LIMIT);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (events_due.size() > 0) begin
            $display("%0t: %0d events still expected, first %0h, actual none",
                     $time, events_due.size(), events_due[0]);
            errors++;
        end
        if (errors == 0 && !timed_out) begin
            $display("i2c_bit_level_master_core test passed");
        end else begin
            $display("i2c_bit_level_master_core test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_ctrl.sv
rtl/core/i2cm_datapath.sv
rtl/core/i2c_bit_level_master_core.sv
tb/sv/tb_i2c_bit_level_master_core.sv
